// File: hw/rtl/double_ended_queue_top_defines.svh
// Assertion macros shared by the deque checker.
// No dependencies; every macro expects clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, idle during reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle implication");

`endif

// File: hw/rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; imported by the controller, datapath, top and checker.
package deq_pkg;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  // Request codes
  localparam req_t REQ_PUSH_FRONT   = 2'd0;
  localparam req_t REQ_PUSH_BACK    = 2'd1;
  localparam req_t REQ_REMOVE_FRONT = 2'd2;
  localparam req_t REQ_REMOVE_BACK  = 2'd3;

  // Result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic do_write;  // push: write slot, move indices
    logic do_read;   // removal: read slot, move indices
    logic reject;    // request fails, state untouched
    logic load_out;  // move the result into the output register
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_push;
    logic empty;
    logic full;
  } deq_stat_t;

endpackage

// File: hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/deq_ctrl.sv
// Controller of the double-ended queue: sequences accept, execute, deliver.
// Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_push) begin
          cmd.do_write = !stat.full;
          cmd.reject   = stat.full;
        end else begin
          cmd.do_read = !stat.empty;
          cmd.reject  = stat.empty;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: cleared on transfer, set on load
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hw/rtl/deq_dp.sv
// Datapath of the double-ended queue: indices, slot store, result registers.
// Depends on deq_pkg and deq_ram.
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  deq_cmd_t                   cmd,
  output deq_stat_t                  stat,
  input  logic [1:0]                 req_type,
  input  logic signed [31:0]         push_value,
  output logic [1:0]                 status,
  output logic signed [31:0]         removed_value,
  output logic [$clog2(DEPTH+1)-1:0] item_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Control state
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] occ, occ_next;

  // Latched request and result
  req_t          req_kind;
  logic [31:0]   req_value;
  status_t       res_status;
  logic          res_took;
  logic [CW-1:0] res_count;

  logic          is_push, is_front;
  logic [AW-1:0] front_dec, front_inc;
  logic [SW-1:0] back_raw, back_wrap;
  logic [AW-1:0] slot_addr;
  logic [31:0]   rd_data;

  assign is_push  = (req_kind == REQ_PUSH_FRONT) || (req_kind == REQ_PUSH_BACK);
  assign is_front = (req_kind == REQ_PUSH_FRONT) || (req_kind == REQ_REMOVE_FRONT);

  assign stat.is_push = is_push;
  assign stat.empty   = (occ == '0);
  assign stat.full    = (occ == CW'(DEPTH));

  // Front neighbors, wrapping at the store ends
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);

  // Back slot: front + occ for a push, front + occ - 1 for a removal
  assign back_raw  = SW'(front) + SW'(occ) - (is_push ? SW'(0) : SW'(1));
  assign back_wrap = (back_raw >= SW'(DEPTH)) ? back_raw - SW'(DEPTH) : back_raw;

  // Slot addressed by this request
  always_comb begin
    case (req_kind)
      REQ_PUSH_FRONT:   slot_addr = front_dec;
      REQ_REMOVE_FRONT: slot_addr = front;
      default:          slot_addr = back_wrap[AW-1:0];
    endcase
  end

  // Index and count update
  always_comb begin
    front_next = front;
    occ_next   = occ;
    if (cmd.do_write) begin
      occ_next = occ + CW'(1);
      if (is_front) begin
        front_next = front_dec;
      end
    end else if (cmd.do_read) begin
      occ_next = occ - CW'(1);
      if (is_front) begin
        front_next = front_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
    end else begin
      front <= front_next;
      occ   <= occ_next;
    end
  end

  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.do_write),
    .wr_addr (slot_addr),
    .wr_data (req_value),
    .rd_en   (cmd.do_read),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  // Request latch, result hold and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= req_type;
      req_value <= push_value;
    end
    if (cmd.do_write || cmd.do_read || cmd.reject) begin
      res_took  <= cmd.do_read;
      res_count <= occ_next;
      if (cmd.reject) begin
        res_status <= is_push ? ST_FULL : ST_EMPTY;
      end else begin
        res_status <= ST_DONE;
      end
    end
    if (cmd.load_out) begin
      status        <= res_status;
      removed_value <= res_took ? rd_data : '0;
      item_count    <= res_count;
    end
  end

endmodule

// File: hw/rtl/double_ended_queue_top.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_ctrl, deq_dp (and deq_ram below it).
//
// Usage:
//   Input channel (in_valid / in_stall) carries req_type and push_value.
//   req_type: push front, push back, remove front, remove back.
//   Output channel (out_valid / out_stall) returns one result per request:
//   status, removed_value (zero unless a removal succeeded) and item_count.
// Timing:
//   A request transfers in S_IDLE, executes in S_EXEC (slot write or slot
//   read in the RAM, index update) and is loaded into the output register
//   in S_DONE; out_valid rises with that load. A new request is taken once
//   the controller is back in S_IDLE, after the previous result is loaded,
//   so requests do not overlap. A result waiting in the output register
//   does not block the next request; the controller holds the next result
//   until the output register is free, so a stalled receiver holds back
//   the input after one request in flight.
// Reset:
//   Synchronous, active high. The queue empties, the front index goes to
//   zero and no result is pending. The slot store needs no clearing pass:
//   only written slots are ever read.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 req_type,
  input  logic signed [31:0]         push_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic signed [31:0]         removed_value,
  output logic [$clog2(DEPTH+1)-1:0] item_count
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .push_value    (push_value),
    .status        (status),
    .removed_value (removed_value),
    .item_count    (item_count)
  );

endmodule

// File: hw/rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_top_defines.svh.
`include "double_ended_queue_top_defines.svh"

module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic signed [31:0]         removed_value,
  input logic [$clog2(DEPTH+1)-1:0] item_count
);

  // A stalled result stays offered
  `DEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // One request at a time: the cycle after a transfer the input is stalled
  `DEQ_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // Only defined status codes leave the block
  `DEQ_ASSERT_NOW(a_status_code, out_valid,
                  status == ST_DONE || status == ST_EMPTY || status == ST_FULL)

  // A failed request returns no word
  `DEQ_ASSERT_NOW(a_removed_zero, out_valid && status != ST_DONE, removed_value == '0)

  // The count never exceeds the store
  `DEQ_ASSERT_NOW(a_count_bound, out_valid, item_count <= ($clog2(DEPTH+1))'(DEPTH))

endmodule

bind double_ended_queue_top deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .removed_value (removed_value),
  .item_count    (item_count)
);

// File: verif/tb_double_ended_queue_top.sv
// Self-checking testbench for double_ended_queue_top: push/remove traffic at both ends.
// A shadow deque predicts status, removed word and count for each request.
// Depends on deq_pkg and the double_ended_queue_top RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed;
    logic [CNT_W-1:0]   occupancy;
  } deq_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_type = REQ_PUSH_FRONT;
  logic signed [31:0]       push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [31:0]       removed_value;
  logic [CNT_W-1:0]         item_count;

  // Shadow deque state
  logic signed [31:0] shadow_slots [DEPTH];
  logic [3:0]         shadow_front = '0;
  logic [CNT_W-1:0]   shadow_count = '0;

  deq_result_t pending_results [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          result_num = 0;

  double_ended_queue_top #(.DEPTH(DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .push_value    (push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .item_count    (item_count)
  );

  always #2 clk = ~clk;

  // Apply one request to the shadow deque and return what the block should report
  function automatic deq_result_t predict_request(req_t kind, logic signed [31:0] word);
    deq_result_t res;
    logic [3:0]  slot;
    res.status  = ST_DONE;
    res.removed = '0;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else if (kind == REQ_PUSH_FRONT) begin
          shadow_front = shadow_front - 4'd1;
          shadow_slots[shadow_front] = word;
          shadow_count = shadow_count + 1'b1;
        end else begin
          slot = shadow_front + shadow_count[3:0];
          shadow_slots[slot] = word;
          shadow_count = shadow_count + 1'b1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (kind == REQ_REMOVE_FRONT) begin
          res.removed = shadow_slots[shadow_front];
          shadow_front = shadow_front + 4'd1;
          shadow_count = shadow_count - 1'b1;
        end else begin
          // count of 16 wraps to 0 in four bits, so front-1 is the back slot
          slot = shadow_front + shadow_count[3:0] - 4'd1;
          res.removed = shadow_slots[slot];
          shadow_count = shadow_count - 1'b1;
        end
      end
    endcase
    res.occupancy = shadow_count;
    return res;
  endfunction

  // Random word, biased toward the extremes
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // One transfer on the request channel, with an optional idle gap first
  task automatic send_request(input req_t kind, input logic signed [31:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    push_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_request(kind, word));
  endtask

  task automatic note_failure(input string what, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("result %0d: %s expected 0x%08h got 0x%08h", result_num, what, exp_v, got_v);
  endtask

  // Result checker
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure("unexpected transfer, status", '0, 32'(status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          note_failure("status", 32'(want.status), 32'(status));
        if (removed_value !== want.removed)
          note_failure("removed_value", want.removed, removed_value);
        if (item_count !== want.occupancy)
          note_failure("item_count", 32'(want.occupancy), 32'(item_count));
      end
      result_num++;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Removals from an empty deque at both ends
  task automatic test_empty_removals();
    send_request(REQ_REMOVE_FRONT, pick_word());
    send_request(REQ_REMOVE_BACK, '1);
  endtask

  // Extreme words through both ends, front index wraps below zero
  task automatic test_extreme_words();
    send_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(REQ_PUSH_BACK, 32'sh8000_0000);
    send_request(REQ_PUSH_FRONT, '0);
    send_request(REQ_PUSH_BACK, '1);
    send_request(REQ_REMOVE_FRONT, 32'sh5555_5555);
    send_request(REQ_REMOVE_BACK, 32'shaaaa_aaaa);
    send_request(REQ_REMOVE_BACK, '0);
    send_request(REQ_REMOVE_FRONT, '1);
  endtask

  // Fill from both ends, then push into the full deque at each end
  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++)
      send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word());
    send_request(REQ_PUSH_FRONT, 32'sh1234_5678);
    send_request(REQ_PUSH_BACK, 32'sh8765_4321);
  endtask

  // Bursts that lean toward pushes or removals so the deque swings full to empty
  task automatic test_random_traffic(input int num_items, input int send_pct,
                                     input int recv_pct);
    int   sent;
    int   burst_len;
    int   push_pct;
    req_t kind;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < num_items) begin
      burst_len = $urandom_range(6, 40);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = (shadow_count > DEPTH / 2) ? 25 : 75;
      endcase
      for (int i = 0; i < burst_len && sent < num_items; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        else
          kind = $urandom_range(0, 1) ? REQ_REMOVE_FRONT : REQ_REMOVE_BACK;
        send_request(kind, pick_word());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_removals();
    test_extreme_words();
    test_fill_and_overflow();
    test_random_traffic(235, 12, 52);
    test_random_traffic(235, 52, 12);
    test_random_traffic(235, 0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("double_ended_queue_top verification clean");
    end else begin
      $display("double_ended_queue_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("double_ended_queue_top verification failed");
    $finish;
  end

endmodule
